// ===== rtl/bbde_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbde_pkg
// Shared types, constants and helpers for the bounding box distance estimator.
// ----------------------------------------------------------------------------
package bbde_pkg;

    localparam int COEF_W   = 48;
    localparam int CFG_W    = 64;
    localparam int ADDR_W   = 6;
    localparam int ADDR_LSB = 3;
    localparam int WORD_W   = 32;
    localparam int HALF_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int THR_W    = 16;
    localparam int NEAR_W   = 8;
    localparam int RES_W    = 16;

    // box width is a difference of two 16-bit values, offset from centre one wider
    localparam int WIDTH_W  = HALF_W + 1;
    localparam int OFFSET_W = HALF_W + 2;

    // digit-serial multiplier: wide operand times narrow signed operand
    localparam int DIGIT_W  = 16;
    localparam int OPA_W    = 96;
    localparam int DIGITS   = OPA_W / DIGIT_W;
    localparam int CNT_W    = $clog2(DIGITS);
    localparam int PP_W     = DIGIT_W + 1 + OFFSET_W;
    localparam int PROD_W   = OPA_W + OFFSET_W;
    localparam int FRAC_W   = 32;

    localparam int CENTRE_COLUMN_DEF = 320;
    localparam int QUEUE_DEPTH_DEF   = 2;

    localparam logic [WORD_W-1:0] TAG_GREEN   = 32'h0047_4747;
    localparam logic [WORD_W-1:0] TAG_PURPLE  = 32'h0050_5050;
    localparam logic [BYTE_W-1:0] REPORT_CHAR = 8'h73;
    localparam logic [HALF_W-1:0] EMPTY_XMIN  = 16'd639;
    localparam logic [HALF_W-1:0] EMPTY_YMIN  = 16'd479;

    localparam logic [COEF_W-1:0] DIST_COEF0_RST  = 48'sd351522199637;
    localparam logic [COEF_W-1:0] DIST_COEF1_RST  = -48'sd3436081211;
    localparam logic [COEF_W-1:0] DIST_COEF2_RST  = 48'sd9357334;
    localparam logic [COEF_W-1:0] SCALE_COEF0_RST = 48'sd719083611;
    localparam logic [COEF_W-1:0] SCALE_COEF1_RST = -48'sd9743949;
    localparam logic [COEF_W-1:0] SCALE_COEF2_RST = 48'sd42799;
    localparam logic [THR_W-1:0]  NEAR_ROW_RST    = 16'd450;
    localparam logic [NEAR_W-1:0] NEAR_DIST_RST   = 8'd26;

    typedef enum logic [2:0] {
        REG_DIST_COEF0  = 3'd0,
        REG_DIST_COEF1  = 3'd1,
        REG_DIST_COEF2  = 3'd2,
        REG_SCALE_COEF0 = 3'd3,
        REG_SCALE_COEF1 = 3'd4,
        REG_SCALE_COEF2 = 3'd5,
        REG_NEAR_ROW    = 3'd6,
        REG_NEAR_DIST   = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2,
        PH_WAIT   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_ADD,
        BK_DONE
    } back_state_t;

    typedef enum logic [2:0] {
        ST_DIST_SQ,
        ST_DIST_LIN,
        ST_SCALE_SQ,
        ST_SCALE_LIN,
        ST_HORIZ
    } step_t;

    typedef struct packed {
        logic [COEF_W-1:0] dist_coef0;
        logic [COEF_W-1:0] dist_coef1;
        logic [COEF_W-1:0] dist_coef2;
        logic [COEF_W-1:0] scale_coef0;
        logic [COEF_W-1:0] scale_coef1;
        logic [COEF_W-1:0] scale_coef2;
        logic [THR_W-1:0]  near_row_threshold;
        logic [NEAR_W-1:0] near_distance;
    } cfg_t;

    typedef struct packed {
        logic                is_purple;
        logic                report;
        logic                report_purple;
        logic                box_empty;
        logic                is_near;
        logic [WIDTH_W-1:0]  width;
        logic [OFFSET_W-1:0] offset;
    } job_t;

    function automatic logic [PROD_W-1:0] coef_wide(input logic [COEF_W-1:0] c);
        return {{(PROD_W-COEF_W){c[COEF_W-1]}}, c};
    endfunction

    // Q.32 to 16 bits: truncate toward zero, then saturate
    function automatic logic [RES_W-1:0] q32_to_s16(input logic [PROD_W-1:0] v);
        logic neg;
        logic hi_any;
        logic hi_all;
        logic inc;
        logic [RES_W-1:0] r;
        neg    = v[PROD_W-1];
        hi_any = |v[PROD_W-2:FRAC_W+RES_W-1];
        hi_all = &v[PROD_W-2:FRAC_W+RES_W-1];
        inc    = neg & (|v[FRAC_W-1:0]);
        if (!neg && hi_any)
            r = {1'b0, {(RES_W-1){1'b1}}};
        else if (neg && !hi_all)
            r = {1'b1, {(RES_W-1){1'b0}}};
        else
            r = v[FRAC_W+RES_W-1:FRAC_W] + {{(RES_W-1){1'b0}}, inc};
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bbde_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbde_regs
// APB configuration registers: polynomial coefficients and near-row settings.
// ----------------------------------------------------------------------------
module bbde_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bbde_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bbde_pkg::CFG_W-1:0]  pwdata,
    output logic      [bbde_pkg::CFG_W-1:0]  prdata,
    output logic                             pready,
    output bbde_pkg::cfg_t                   cfg
);

    bbde_pkg::cfg_t     cfg_reg;
    bbde_pkg::cfg_t     cfg_next;
    bbde_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = bbde_pkg::reg_idx_t'(paddr[bbde_pkg::ADDR_W-1:bbde_pkg::ADDR_LSB]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                bbde_pkg::REG_DIST_COEF0:  cfg_next.dist_coef0  = pwdata[bbde_pkg::COEF_W-1:0];
                bbde_pkg::REG_DIST_COEF1:  cfg_next.dist_coef1  = pwdata[bbde_pkg::COEF_W-1:0];
                bbde_pkg::REG_DIST_COEF2:  cfg_next.dist_coef2  = pwdata[bbde_pkg::COEF_W-1:0];
                bbde_pkg::REG_SCALE_COEF0: cfg_next.scale_coef0 = pwdata[bbde_pkg::COEF_W-1:0];
                bbde_pkg::REG_SCALE_COEF1: cfg_next.scale_coef1 = pwdata[bbde_pkg::COEF_W-1:0];
                bbde_pkg::REG_SCALE_COEF2: cfg_next.scale_coef2 = pwdata[bbde_pkg::COEF_W-1:0];
                bbde_pkg::REG_NEAR_ROW:
                    cfg_next.near_row_threshold = pwdata[bbde_pkg::THR_W-1:0];
                bbde_pkg::REG_NEAR_DIST:
                    cfg_next.near_distance = pwdata[bbde_pkg::NEAR_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            bbde_pkg::REG_DIST_COEF0:  prdata = bbde_pkg::CFG_W'($signed(cfg_reg.dist_coef0));
            bbde_pkg::REG_DIST_COEF1:  prdata = bbde_pkg::CFG_W'($signed(cfg_reg.dist_coef1));
            bbde_pkg::REG_DIST_COEF2:  prdata = bbde_pkg::CFG_W'($signed(cfg_reg.dist_coef2));
            bbde_pkg::REG_SCALE_COEF0: prdata = bbde_pkg::CFG_W'($signed(cfg_reg.scale_coef0));
            bbde_pkg::REG_SCALE_COEF1: prdata = bbde_pkg::CFG_W'($signed(cfg_reg.scale_coef1));
            bbde_pkg::REG_SCALE_COEF2: prdata = bbde_pkg::CFG_W'($signed(cfg_reg.scale_coef2));
            bbde_pkg::REG_NEAR_ROW:    prdata = bbde_pkg::CFG_W'(cfg_reg.near_row_threshold);
            bbde_pkg::REG_NEAR_DIST:   prdata = bbde_pkg::CFG_W'(cfg_reg.near_distance);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dist_coef0         <= bbde_pkg::DIST_COEF0_RST;
            cfg_reg.dist_coef1         <= bbde_pkg::DIST_COEF1_RST;
            cfg_reg.dist_coef2         <= bbde_pkg::DIST_COEF2_RST;
            cfg_reg.scale_coef0        <= bbde_pkg::SCALE_COEF0_RST;
            cfg_reg.scale_coef1        <= bbde_pkg::SCALE_COEF1_RST;
            cfg_reg.scale_coef2        <= bbde_pkg::SCALE_COEF2_RST;
            cfg_reg.near_row_threshold <= bbde_pkg::NEAR_ROW_RST;
            cfg_reg.near_distance      <= bbde_pkg::NEAR_DIST_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bbde_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbde_front
// Message parser: tracks tags and coordinate words, arms host reports and
// hands each complete box, already classified, to the job queue.
// ----------------------------------------------------------------------------
module bbde_front #(
    parameter int CENTRE_COLUMN = bbde_pkg::CENTRE_COLUMN_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic                        action,
    input  wire logic [bbde_pkg::WORD_W-1:0] message_word,
    input  wire logic [bbde_pkg::BYTE_W-1:0] host_byte,
    input  bbde_pkg::cfg_t                   cfg,
    input  wire logic                        q_full,
    output logic                             job_push,
    output bbde_pkg::job_t                   job
);

    localparam int HW = bbde_pkg::HALF_W;
    localparam int WW = bbde_pkg::WIDTH_W;
    localparam int OW = bbde_pkg::OFFSET_W;

    bbde_pkg::phase_t phase_reg;
    bbde_pkg::phase_t phase_next;
    logic             colour_reg;
    logic             colour_next;
    logic             armed_reg;
    logic             armed_next;
    logic             rep_purple_reg;
    logic             rep_purple_next;
    logic [HW-1:0]    first_x_reg;
    logic [HW-1:0]    first_x_next;
    logic [HW-1:0]    first_y_reg;
    logic [HW-1:0]    first_y_next;

    logic          accept;
    logic          is_tag;
    logic [HW-1:0] hx;
    logic [HW-1:0] ly;
    logic [WW-1:0] xmin_e;
    logic [WW-1:0] xmax_e;
    logic [WW-1:0] width;
    logic [WW-1:0] width_adj;
    logic [WW-1:0] half_width;
    logic [OW-1:0] mid_y;
    logic [WW-1:0] sum_x;
    logic [WW-1:0] sum_x_adj;
    logic [WW-1:0] mid_x;

    assign full   = q_full;
    assign accept = push & ~q_full;
    assign hx     = message_word[bbde_pkg::WORD_W-1:HW];
    assign ly     = message_word[HW-1:0];
    assign is_tag = (message_word == bbde_pkg::TAG_GREEN) ||
                    (message_word == bbde_pkg::TAG_PURPLE);

    // box geometry; halving truncates toward zero
    assign xmin_e     = {first_x_reg[HW-1], first_x_reg};
    assign xmax_e     = {hx[HW-1], hx};
    assign width      = xmax_e - xmin_e;
    assign width_adj  = width + {{(WW-1){1'b0}}, width[WW-1]};
    assign half_width = {width_adj[WW-1], width_adj[WW-1:1]};
    assign mid_y      = {{(OW-HW){first_y_reg[HW-1]}}, first_y_reg} +
                        {{(OW-WW){half_width[WW-1]}}, half_width};
    assign sum_x      = xmin_e + xmax_e;
    assign sum_x_adj  = sum_x + {{(WW-1){1'b0}}, sum_x[WW-1]};
    assign mid_x      = {sum_x_adj[WW-1], sum_x_adj[WW-1:1]};

    always_comb
    begin
        job.is_purple     = colour_reg;
        job.report        = armed_reg;
        job.report_purple = rep_purple_reg;
        job.box_empty     = (first_x_reg == bbde_pkg::EMPTY_XMIN) &&
                            (first_y_reg == bbde_pkg::EMPTY_YMIN) &&
                            (hx == '0) && (ly == '0);
        job.is_near       = $signed(mid_y) >
                            $signed({{(OW-bbde_pkg::THR_W){1'b0}}, cfg.near_row_threshold});
        job.width         = width;
        job.offset        = {{(OW-WW){mid_x[WW-1]}}, mid_x} - OW'(CENTRE_COLUMN);
    end

    always_comb
    begin
        phase_next      = phase_reg;
        colour_next     = colour_reg;
        armed_next      = armed_reg;
        rep_purple_next = rep_purple_reg;
        first_x_next    = first_x_reg;
        first_y_next    = first_y_reg;
        job_push        = 1'b0;
        if (accept)
        begin
            if (action)
            begin
                armed_next = (host_byte == bbde_pkg::REPORT_CHAR);
            end
            else
            begin
                unique case (phase_reg)
                    bbde_pkg::PH_FIRST:
                    begin
                        first_x_next = hx;
                        first_y_next = ly;
                        phase_next   = bbde_pkg::PH_SECOND;
                    end
                    bbde_pkg::PH_SECOND:
                    begin
                        job_push   = 1'b1;
                        phase_next = bbde_pkg::PH_WAIT;
                        if (armed_reg)
                        begin
                            armed_next      = 1'b0;
                            rep_purple_next = ~rep_purple_reg;
                        end
                    end
                    default: phase_next = phase_reg;
                endcase
                if (is_tag)
                begin
                    colour_next = (message_word == bbde_pkg::TAG_PURPLE);
                    phase_next  = bbde_pkg::PH_FIRST;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= bbde_pkg::PH_WAIT;
            colour_reg     <= 1'b0;
            armed_reg      <= 1'b0;
            rep_purple_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            colour_reg     <= colour_next;
            armed_reg      <= armed_next;
            rep_purple_reg <= rep_purple_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_x_reg <= first_x_next;
        first_y_reg <= first_y_next;
    end

endmodule
`default_nettype wire

// ===== rtl/bbde_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbde_queue
// Small job queue between the parser and the arithmetic back end.
// ----------------------------------------------------------------------------
module bbde_queue #(
    parameter int DEPTH = bbde_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_en,
    input  bbde_pkg::job_t wr_data,
    output logic           full,
    input  wire logic      rd_en,
    output bbde_pkg::job_t rd_data,
    output logic           empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bbde_pkg::job_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & ~empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule
`default_nettype wire

// ===== rtl/bbde_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbde_back
// Arithmetic back end: evaluates both width polynomials and the offset
// product on one digit-serial multiplier, saturates, stores the latest
// values per colour and holds the result item for the output side.
// ----------------------------------------------------------------------------
module bbde_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  bbde_pkg::cfg_t                  cfg,
    input  wire logic                       job_empty,
    input  bbde_pkg::job_t                  job,
    output logic                            job_pop,
    input  wire logic                       pop,
    output logic                            empty,
    output logic [bbde_pkg::RES_W-1:0]      distance_cm,
    output logic [bbde_pkg::RES_W-1:0]      horizontal_cm,
    output logic                            box_is_purple,
    output logic                            report_valid,
    output logic                            report_is_purple,
    output logic [bbde_pkg::RES_W-1:0]      report_distance,
    output logic [bbde_pkg::RES_W-1:0]      report_horizontal
);

    localparam int OPA_W  = bbde_pkg::OPA_W;
    localparam int PROD_W = bbde_pkg::PROD_W;
    localparam int OW     = bbde_pkg::OFFSET_W;
    localparam int WW     = bbde_pkg::WIDTH_W;
    localparam int DW     = bbde_pkg::DIGIT_W;
    localparam int PP_W   = bbde_pkg::PP_W;
    localparam int CNT_W  = bbde_pkg::CNT_W;
    localparam int RW     = bbde_pkg::RES_W;

    bbde_pkg::back_state_t state_reg;
    bbde_pkg::back_state_t state_next;
    bbde_pkg::step_t       step_reg;
    bbde_pkg::step_t       step_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [OPA_W-1:0]      opa_reg;
    logic [OPA_W-1:0]      opa_next;
    logic [OW-1:0]         opb_reg;
    logic [OW-1:0]         opb_next;
    logic [PROD_W-1:0]     prod_reg;
    logic [PROD_W-1:0]     prod_next;
    logic [PROD_W-1:0]     dist_wide_reg;
    logic [PROD_W-1:0]     dist_wide_next;
    bbde_pkg::job_t        job_reg;
    bbde_pkg::job_t        job_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [RW-1:0] dist_out_reg;
    logic [RW-1:0] dist_out_next;
    logic [RW-1:0] hor_out_reg;
    logic [RW-1:0] hor_out_next;
    logic          purple_out_reg;
    logic          purple_out_next;
    logic          rep_out_reg;
    logic          rep_out_next;
    logic          rep_purple_out_reg;
    logic          rep_purple_out_next;
    logic [RW-1:0] rep_dist_out_reg;
    logic [RW-1:0] rep_dist_out_next;
    logic [RW-1:0] rep_hor_out_reg;
    logic [RW-1:0] rep_hor_out_next;
    logic [RW-1:0] latest_dist_reg [2];
    logic [RW-1:0] latest_dist_next [2];
    logic [RW-1:0] latest_hor_reg [2];
    logic [RW-1:0] latest_hor_next [2];

    logic                          first_digit;
    logic [DW-1:0]                 digit;
    logic [DW:0]                   digit_ext;
    logic signed [PP_W-1:0]        pp;
    logic [bbde_pkg::COEF_W-1:0]   addend;
    logic [PROD_W-1:0]             sum_wide;
    logic [OW-1:0]                 width_ext;
    logic [RW-1:0]                 dist_val;
    logic [RW-1:0]                 hor_val;
    logic                          out_load;

    assign empty             = ~out_valid_reg;
    assign distance_cm       = dist_out_reg;
    assign horizontal_cm     = hor_out_reg;
    assign box_is_purple     = purple_out_reg;
    assign report_valid      = rep_out_reg;
    assign report_is_purple  = rep_purple_out_reg;
    assign report_distance   = rep_dist_out_reg;
    assign report_horizontal = rep_hor_out_reg;

    // one 17x18 product per cycle, most significant digit first
    assign first_digit = (cnt_reg == CNT_W'(bbde_pkg::DIGITS - 1));
    assign digit       = opa_reg[OPA_W-1 -: DW];
    assign digit_ext   = {first_digit & digit[DW-1], digit};
    assign pp          = $signed(digit_ext) * $signed(opb_reg);

    assign width_ext = {{(OW-WW){job_reg.width[WW-1]}}, job_reg.width};
    assign sum_wide  = prod_reg + bbde_pkg::coef_wide(addend);

    always_comb
    begin
        unique case (step_reg)
            bbde_pkg::ST_DIST_SQ:   addend = cfg.dist_coef1;
            bbde_pkg::ST_DIST_LIN:  addend = cfg.dist_coef0;
            bbde_pkg::ST_SCALE_SQ:  addend = cfg.scale_coef1;
            bbde_pkg::ST_SCALE_LIN: addend = cfg.scale_coef0;
            default:                addend = '0;
        endcase
    end

    always_comb
    begin
        if (job_reg.box_empty)
            dist_val = '0;
        else if (job_reg.is_near)
            dist_val = RW'(cfg.near_distance);
        else
            dist_val = bbde_pkg::q32_to_s16(dist_wide_reg);
        hor_val = bbde_pkg::q32_to_s16(prod_reg);
    end

    always_comb
    begin
        state_next          = state_reg;
        step_next           = step_reg;
        cnt_next            = cnt_reg;
        opa_next            = opa_reg;
        opb_next            = opb_reg;
        prod_next           = prod_reg;
        dist_wide_next      = dist_wide_reg;
        job_next            = job_reg;
        job_pop             = 1'b0;
        out_load            = 1'b0;
        latest_dist_next    = latest_dist_reg;
        latest_hor_next     = latest_hor_reg;
        dist_out_next       = dist_out_reg;
        hor_out_next        = hor_out_reg;
        purple_out_next     = purple_out_reg;
        rep_out_next        = rep_out_reg;
        rep_purple_out_next = rep_purple_out_reg;
        rep_dist_out_next   = rep_dist_out_reg;
        rep_hor_out_next    = rep_hor_out_reg;

        unique case (state_reg)
            bbde_pkg::BK_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop    = 1'b1;
                    job_next   = job;
                    opa_next   = OPA_W'(bbde_pkg::coef_wide(cfg.dist_coef2));
                    opb_next   = {{(OW-WW){job.width[WW-1]}}, job.width};
                    cnt_next   = CNT_W'(bbde_pkg::DIGITS - 1);
                    step_next  = bbde_pkg::ST_DIST_SQ;
                    state_next = bbde_pkg::BK_MUL;
                end
            end
            bbde_pkg::BK_MUL:
            begin
                prod_next = (first_digit ? '0 : (prod_reg << DW)) +
                            {{(PROD_W-PP_W){pp[PP_W-1]}}, pp};
                opa_next  = opa_reg << DW;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = bbde_pkg::BK_ADD;
            end
            bbde_pkg::BK_ADD:
            begin
                cnt_next   = CNT_W'(bbde_pkg::DIGITS - 1);
                state_next = bbde_pkg::BK_MUL;
                unique case (step_reg)
                    bbde_pkg::ST_DIST_SQ:
                    begin
                        opa_next  = sum_wide[OPA_W-1:0];
                        opb_next  = width_ext;
                        step_next = bbde_pkg::ST_DIST_LIN;
                    end
                    bbde_pkg::ST_DIST_LIN:
                    begin
                        dist_wide_next = sum_wide;
                        opa_next  = OPA_W'(bbde_pkg::coef_wide(cfg.scale_coef2));
                        opb_next  = width_ext;
                        step_next = bbde_pkg::ST_SCALE_SQ;
                    end
                    bbde_pkg::ST_SCALE_SQ:
                    begin
                        opa_next  = sum_wide[OPA_W-1:0];
                        opb_next  = width_ext;
                        step_next = bbde_pkg::ST_SCALE_LIN;
                    end
                    bbde_pkg::ST_SCALE_LIN:
                    begin
                        opa_next  = sum_wide[OPA_W-1:0];
                        opb_next  = job_reg.offset;
                        step_next = bbde_pkg::ST_HORIZ;
                    end
                    default:
                    begin
                        state_next = bbde_pkg::BK_DONE;
                    end
                endcase
            end
            bbde_pkg::BK_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_load = 1'b1;
                    latest_dist_next[job_reg.is_purple] = dist_val;
                    latest_hor_next[job_reg.is_purple]  = hor_val;
                    dist_out_next       = dist_val;
                    hor_out_next        = hor_val;
                    purple_out_next     = job_reg.is_purple;
                    rep_out_next        = job_reg.report;
                    rep_purple_out_next = job_reg.report & job_reg.report_purple;
                    rep_dist_out_next   = '0;
                    rep_hor_out_next    = '0;
                    if (job_reg.report)
                    begin
                        if (job_reg.report_purple == job_reg.is_purple)
                        begin
                            rep_dist_out_next = dist_val;
                            rep_hor_out_next  = hor_val;
                        end
                        else
                        begin
                            rep_dist_out_next = latest_dist_reg[job_reg.report_purple];
                            rep_hor_out_next  = latest_hor_reg[job_reg.report_purple];
                        end
                    end
                    state_next = bbde_pkg::BK_IDLE;
                end
            end
            default: state_next = bbde_pkg::BK_IDLE;
        endcase

        out_valid_next = out_load | (out_valid_reg & ~pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= bbde_pkg::BK_IDLE;
            step_reg           <= bbde_pkg::ST_DIST_SQ;
            cnt_reg            <= '0;
            out_valid_reg      <= 1'b0;
            latest_dist_reg[0] <= '0;
            latest_dist_reg[1] <= '0;
            latest_hor_reg[0]  <= '0;
            latest_hor_reg[1]  <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            step_reg           <= step_next;
            cnt_reg            <= cnt_next;
            out_valid_reg      <= out_valid_next;
            latest_dist_reg[0] <= latest_dist_next[0];
            latest_dist_reg[1] <= latest_dist_next[1];
            latest_hor_reg[0]  <= latest_hor_next[0];
            latest_hor_reg[1]  <= latest_hor_next[1];
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg            <= opa_next;
        opb_reg            <= opb_next;
        prod_reg           <= prod_next;
        dist_wide_reg      <= dist_wide_next;
        job_reg            <= job_next;
        dist_out_reg       <= dist_out_next;
        hor_out_reg        <= hor_out_next;
        purple_out_reg     <= purple_out_next;
        rep_out_reg        <= rep_out_next;
        rep_purple_out_reg <= rep_purple_out_next;
        rep_dist_out_reg   <= rep_dist_out_next;
        rep_hor_out_reg    <= rep_hor_out_next;
    end

endmodule
`default_nettype wire

// ===== rtl/bounding_box_distance_estimator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Tag words, first coordinate words, ignored words and host bytes are taken
// one per cycle while the job queue has room. Each second coordinate word
// becomes a job for the arithmetic back end, which handles it in steps: a
// load step, five multiplications of six 16-bit digit steps each on one
// shared 17x18 multiplier with an add step after each, and an output step.
// full rises while QUEUE_DEPTH boxes wait for the back end; the finished item
// sits in an output register, so the back end starts the next box while it
// waits to be popped.
// ----------------------------------------------------------------------------
// bounding_box_distance_estimator
// Parses box records from an image processor, estimates distance and
// sideways offset per box and reports the latest values on host request.
// ----------------------------------------------------------------------------
module bounding_box_distance_estimator #(
    parameter int CENTRE_COLUMN = bbde_pkg::CENTRE_COLUMN_DEF,
    parameter int QUEUE_DEPTH   = bbde_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic                        action,
    input  wire logic [bbde_pkg::WORD_W-1:0] message_word,
    input  wire logic [bbde_pkg::BYTE_W-1:0] host_byte,
    output logic                             empty,
    input  wire logic                        pop,
    output logic      [bbde_pkg::RES_W-1:0]  distance_cm,
    output logic      [bbde_pkg::RES_W-1:0]  horizontal_cm,
    output logic                             box_is_purple,
    output logic                             report_valid,
    output logic                             report_is_purple,
    output logic      [bbde_pkg::RES_W-1:0]  report_distance,
    output logic      [bbde_pkg::RES_W-1:0]  report_horizontal,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bbde_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bbde_pkg::CFG_W-1:0]  pwdata,
    output logic      [bbde_pkg::CFG_W-1:0]  prdata,
    output logic                             pready
);

    bbde_pkg::cfg_t cfg;
    bbde_pkg::job_t job_in;
    bbde_pkg::job_t job_out;
    logic           job_push;
    logic           job_pop;
    logic           q_full;
    logic           q_empty;

    bbde_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bbde_front #(
        .CENTRE_COLUMN (CENTRE_COLUMN)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .action       (action),
        .message_word (message_word),
        .host_byte    (host_byte),
        .cfg          (cfg),
        .q_full       (q_full),
        .job_push     (job_push),
        .job          (job_in)
    );

    bbde_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (q_full),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .empty   (q_empty)
    );

    bbde_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .job_empty         (q_empty),
        .job               (job_out),
        .job_pop           (job_pop),
        .pop               (pop),
        .empty             (empty),
        .distance_cm       (distance_cm),
        .horizontal_cm     (horizontal_cm),
        .box_is_purple     (box_is_purple),
        .report_valid      (report_valid),
        .report_is_purple  (report_is_purple),
        .report_distance   (report_distance),
        .report_horizontal (report_horizontal)
    );

endmodule
`default_nettype wire
